>>> design/xdr_pkg.sv
// ----------------------------------------------------------------------------
// xdr_pkg
// Shared constants and controller/datapath handshake types for the XOR-delta
// run-length decoder.
// ----------------------------------------------------------------------------
package xdr_pkg;

  localparam int BL_DEPTH = 4096;
  localparam int BL_AW    = $clog2(BL_DEPTH);
  localparam int BL_LW    = $clog2(BL_DEPTH + 1);
  localparam int BPR      = 8;

  localparam logic [31:0] FNV_INIT  = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [3:0]  HDR_BYTES = 4'd9;
  localparam logic [7:0]  REPEAT_BIT = 8'h80;
  localparam logic [7:0]  LEN_MASK   = 8'h7F;

  localparam logic [1:0] MODE_CONTROL = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_CORRUPT   = 2'd2;
  localparam logic [1:0] ST_MISMATCH  = 2'd3;

  typedef struct packed {
    logic take;
    logic fold;
    logic emit_data;
    logic emit_status;
  } xdr_cmd_t;

  typedef struct packed {
    logic ecnt_zero;
    logic pack_full;
    logic pack_empty;
    logic status_due;
    logic out_free;
  } xdr_stat_t;

endpackage

>>> design/xdr_if.sv
// ----------------------------------------------------------------------------
// xdr channel interfaces
// Valid/ready channels for input items, result items and the tag register.
// ----------------------------------------------------------------------------
interface xdr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;
  logic       last;
  modport source (output valid, output op, output byte_value, output last, input ready);
  modport sink   (input valid, input op, input byte_value, input last, output ready);
endinterface

interface xdr_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic [1:0]  status;
  logic        final_res;
  modport source (output valid, output data_word, output byte_count, output status,
                  output final_res, input ready);
  modport sink   (input valid, input data_word, input byte_count, input status,
                  input final_res, output ready);
endinterface

interface xdr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_tag;
  modport source (output valid, output frame_tag, input ready);
  modport sink   (input valid, input frame_tag, output ready);
endinterface

>>> design/xdr_ctrl.sv
// ----------------------------------------------------------------------------
// xdr_ctrl
// Sequencer: takes items, steps the byte expansion and schedules results.
// ----------------------------------------------------------------------------
module xdr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  xdr_pkg::xdr_stat_t st,
  output xdr_pkg::xdr_cmd_t  cmd
);
  import xdr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXP  = 3'd1;
  localparam logic [2:0] S_FOLD = 3'd2;
  localparam logic [2:0] S_EMD  = 3'd3;
  localparam logic [2:0] S_EMS  = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_EXP;
        end
      end
      S_EXP: begin
        if (!st.ecnt_zero) begin
          state_nxt = st.pack_full ? S_EMD : S_FOLD;
        end else if (!st.pack_empty) begin
          state_nxt = S_EMD;
        end else if (st.status_due) begin
          state_nxt = S_EMS;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = S_EXP;
      end
      S_EMD: begin
        if (st.out_free) begin
          cmd.emit_data = 1'b1;
          state_nxt     = S_EXP;
        end
      end
      S_EMS: begin
        if (st.out_free) begin
          cmd.emit_status = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/xdr_dp.sv
// ----------------------------------------------------------------------------
// xdr_dp
// Datapath: baseline store and hash, header and run state, byte fold,
// result packing and the output register.
// ----------------------------------------------------------------------------
module xdr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  xdr_pkg::xdr_cmd_t  cmd,
  output xdr_pkg::xdr_stat_t st,
  input  logic              in_op,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_tag,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [63:0]       out_data,
  output logic [3:0]        out_count,
  output logic [1:0]        out_status,
  output logic              out_final
);
  import xdr_pkg::*;

  logic [7:0]       mem [BL_DEPTH];
  logic [7:0]       mem_q;
  logic             mem_we;
  logic [BL_AW-1:0] mem_wa;

  logic [7:0]       tag_r;
  logic [BL_LW-1:0] blen_r, blen_nxt;
  logic [31:0]      bhash_r, bhash_nxt;
  logic             open_r, open_nxt, ovf_r, ovf_nxt;
  logic [3:0]       hp_r, hp_nxt;
  logic [31:0]      size_r, size_nxt, hh_r, hh_nxt, oc_r, oc_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic             mis_r, mis_nxt, cor_r, cor_nxt;
  logic [7:0]       b_r, b_nxt, ecnt_r, ecnt_nxt;
  logic             due_r, due_nxt;
  logic [63:0]      pack_r, pack_nxt;
  logic [3:0]       pcnt_r, pcnt_nxt;
  logic             ov_r, ov_nxt;
  logic [63:0]      od_r, od_nxt;
  logic [3:0]       oc4_r, oc4_nxt;
  logic [1:0]       os_r, os_nxt;
  logic             of_r, of_nxt;

  logic [31:0]      h0;
  logic [BL_LW-1:0] len0;
  logic [63:0]      prod;
  logic [7:0]       len;
  logic [32:0]      run_end;
  logic [7:0]       fbyte;
  logic [1:0]       stv;

  always_comb begin
    blen_nxt = blen_r;  bhash_nxt = bhash_r; open_nxt = open_r; ovf_nxt = ovf_r;
    hp_nxt   = hp_r;    size_nxt  = size_r;  hh_nxt   = hh_r;   oc_nxt  = oc_r;
    mode_nxt = mode_r;  rem_nxt   = rem_r;   mis_nxt  = mis_r;  cor_nxt = cor_r;
    b_nxt    = b_r;     ecnt_nxt  = ecnt_r;  due_nxt  = due_r;
    pack_nxt = pack_r;  pcnt_nxt  = pcnt_r;
    ov_nxt   = ov_r && !out_ready;
    od_nxt   = od_r;    oc4_nxt   = oc4_r;   os_nxt   = os_r;   of_nxt  = of_r;
    mem_we   = 1'b0;
    h0       = open_r ? bhash_r : FNV_INIT;
    len0     = open_r ? blen_r : '0;
    prod     = (h0 ^ {24'd0, in_byte}) * FNV_PRIME;
    mem_wa   = len0[BL_AW-1:0];
    len      = (in_byte & LEN_MASK) + 8'd1;
    run_end  = {1'b0, oc_r} + {25'd0, len};
    fbyte    = (oc_r < {{(32-BL_LW){1'b0}}, blen_r}) ? (b_r ^ mem_q) : b_r;
    stv      = ST_OK;

    if (cmd.take) begin
      b_nxt    = in_byte;
      due_nxt  = in_op & in_last;
      ecnt_nxt = '0;
      if (!in_op) begin
        if (hp_r == 4'd0) begin
          bhash_nxt = prod[31:0];
          open_nxt  = !in_last;
          if (len0 < BL_LW'(BL_DEPTH)) begin
            mem_we   = 1'b1;
            blen_nxt = len0 + 1'b1;
            ovf_nxt  = open_r & ovf_r;
          end else begin
            blen_nxt = len0;
            ovf_nxt  = 1'b1;
          end
        end
      end else if (hp_r < HDR_BYTES) begin
        if (hp_r == 4'd0) begin
          if (in_byte != tag_r) mis_nxt = 1'b1;
        end else if (hp_r <= 4'd4) begin
          size_nxt = size_r | ({24'd0, in_byte} << {hp_r[1:0] - 2'd1, 3'd0});
        end else begin
          hh_nxt = hh_r | ({24'd0, in_byte} << {hp_r[1:0] - 2'd1, 3'd0});
        end
        hp_nxt = hp_r + 4'd1;
        if (hp_r == 4'd8 && ({in_byte, hh_r[23:0]} != bhash_r || ovf_r)) mis_nxt = 1'b1;
      end else if (!mis_r && !cor_r && size_r != 32'd0) begin
        case (mode_r)
          MODE_CONTROL: begin
            if (run_end > {1'b0, size_r}) begin
              cor_nxt = 1'b1;
            end else begin
              mode_nxt = (in_byte & REPEAT_BIT) != 8'd0 ? MODE_REPEAT : MODE_LITERAL;
              rem_nxt  = len;
            end
          end
          MODE_LITERAL: begin
            ecnt_nxt = 8'd1;
            rem_nxt  = rem_r - 8'd1;
            if (rem_r == 8'd1) mode_nxt = MODE_CONTROL;
          end
          default: begin
            ecnt_nxt = rem_r;
            rem_nxt  = '0;
            mode_nxt = MODE_CONTROL;
          end
        endcase
      end
    end

    if (cmd.fold) begin
      pack_nxt = pack_r | ({56'd0, fbyte} << {pcnt_r[2:0], 3'd0});
      pcnt_nxt = pcnt_r + 4'd1;
      oc_nxt   = oc_r + 32'd1;
      ecnt_nxt = ecnt_r - 8'd1;
    end

    if (cmd.emit_data) begin
      ov_nxt   = 1'b1;
      od_nxt   = pack_r;
      oc4_nxt  = pcnt_r;
      os_nxt   = ST_OK;
      of_nxt   = 1'b0;
      pack_nxt = '0;
      pcnt_nxt = '0;
    end

    if (hp_r < HDR_BYTES)                                  stv = ST_TRUNCATED;
    else if (mis_r)                                        stv = ST_MISMATCH;
    else if (size_r == 32'd0)                              stv = ST_OK;
    else if (cor_r || mode_r != MODE_CONTROL || oc_r != size_r) stv = ST_CORRUPT;

    if (cmd.emit_status) begin
      ov_nxt   = 1'b1;
      od_nxt   = '0;
      oc4_nxt  = '0;
      os_nxt   = stv;
      of_nxt   = 1'b1;
      // drop all frame state, keep the baseline
      hp_nxt   = '0; size_nxt = '0; hh_nxt = '0; oc_nxt = '0;
      mode_nxt = MODE_CONTROL; rem_nxt = '0; mis_nxt = 1'b0; cor_nxt = 1'b0;
      due_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= in_byte;
    mem_q <= mem[oc_r[BL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r  <= '0;  blen_r <= '0;  bhash_r <= FNV_INIT; open_r <= 1'b0; ovf_r <= 1'b0;
      hp_r   <= '0;  size_r <= '0;  hh_r    <= '0;       oc_r   <= '0;
      mode_r <= MODE_CONTROL; rem_r <= '0; mis_r <= 1'b0; cor_r <= 1'b0;
      ecnt_r <= '0;  due_r  <= 1'b0; pcnt_r <= '0; pack_r <= '0; ov_r <= 1'b0;
    end else begin
      if (cfg_we) tag_r <= cfg_tag;
      blen_r <= blen_nxt; bhash_r <= bhash_nxt; open_r <= open_nxt; ovf_r <= ovf_nxt;
      hp_r   <= hp_nxt;   size_r  <= size_nxt;  hh_r   <= hh_nxt;   oc_r  <= oc_nxt;
      mode_r <= mode_nxt; rem_r   <= rem_nxt;   mis_r  <= mis_nxt;  cor_r <= cor_nxt;
      ecnt_r <= ecnt_nxt; due_r   <= due_nxt;   pcnt_r <= pcnt_nxt; pack_r <= pack_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r  <= b_nxt;
    od_r <= od_nxt; oc4_r <= oc4_nxt; os_r <= os_nxt; of_r <= of_nxt;
  end

  assign st.ecnt_zero  = (ecnt_r == 8'd0);
  assign st.pack_full  = (pcnt_r == 4'(BPR));
  assign st.pack_empty = (pcnt_r == 4'd0);
  assign st.status_due = due_r;
  assign st.out_free   = !ov_r || out_ready;

  assign out_valid  = ov_r;
  assign out_data   = od_r;
  assign out_count  = oc4_r;
  assign out_status = os_r;
  assign out_final  = of_r;

endmodule

>>> design/xor_delta_rle_decoder.sv
// ----------------------------------------------------------------------------
// xor_delta_rle_decoder
// Decodes run-length XOR-delta frames against a stored, FNV-1a hashed baseline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one byte per item: op 0 loads the baseline, op 1 feeds a
//          frame (9-byte header, then control/value run bytes). last closes
//          the baseline load or the frame.
//   out_ch carries up to eight decoded bytes per item, earliest in bits 7:0,
//          and, after the last frame byte, one closing item with final_res
//          set and the status. Discard the frame's data unless status is ok.
//   cfg_ch writes the expected frame tag; write it only while idle.
// Sequencing: every decoded byte needs a baseline memory read and then a
//   fold, and every result handed to the output register is first picked
//   and then loaded. A new item is taken only once the sequencer is done
//   with the last one.
// Reset clears the baseline length, hash and all frame state; the stored
//   baseline bytes are left as they are. A stalled receiver holds the
//   output register and the sequencer waits; no result is ever dropped.
// ----------------------------------------------------------------------------
module xor_delta_rle_decoder (
  input  logic clk,
  input  logic rst_n,
  xdr_in_if.sink    in_ch,
  xdr_out_if.source out_ch,
  xdr_cfg_if.sink   cfg_ch
);
  import xdr_pkg::*;

  xdr_cmd_t  cmd;
  xdr_stat_t st;

  // the tag register is always writable
  assign cfg_ch.ready = 1'b1;

  // sequencer: owns in_ready, steps expansion and emission
  xdr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath: baseline memory, run state, packing and output register
  xdr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_op      (in_ch.op),
    .in_byte    (in_ch.byte_value),
    .in_last    (in_ch.last),
    .cfg_we     (cfg_ch.valid),
    .cfg_tag    (cfg_ch.frame_tag),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data_word),
    .out_count  (out_ch.byte_count),
    .out_status (out_ch.status),
    .out_final  (out_ch.final_res)
  );

endmodule
